// ----- hw/rtl/asmg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asmg_pkg
// Shared constants, register indexes and the CORDIC angle table for the
// annulus sector mesh generator.
// ----------------------------------------------------------------------------
package asmg_pkg;

    localparam int MAX_SEGMENTS_DEF  = 256;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int IDX_W  = 8;
    localparam int CNT_W  = 9;
    localparam int CFG_W  = 17;
    localparam int ANG_W  = 32;
    localparam int TRIG_W = 32;

    typedef enum logic [2:0] {
        REG_CENTER_X      = 3'd0,
        REG_CENTER_Y      = 3'd1,
        REG_INNER_RADIUS  = 3'd2,
        REG_OUTER_RADIUS  = 3'd3,
        REG_START_ANGLE   = 3'd4,
        REG_SWEEP         = 3'd5,
        REG_SEGMENT_COUNT = 3'd6
    } reg_idx_t;

    // CORDIC gain-compensated start vector, Q2.30.
    localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 32'sd652032874;

    function automatic logic signed [ANG_W:0] atan_turns(input int k);
        logic signed [ANG_W:0] r;
        begin
            case (k)
                0:  r = 33'sd536870912;
                1:  r = 33'sd316933406;
                2:  r = 33'sd167458907;
                3:  r = 33'sd85004756;
                4:  r = 33'sd42667331;
                5:  r = 33'sd21354465;
                6:  r = 33'sd10679838;
                7:  r = 33'sd5340245;
                8:  r = 33'sd2670163;
                9:  r = 33'sd1335087;
                10: r = 33'sd667544;
                11: r = 33'sd333772;
                12: r = 33'sd166886;
                13: r = 33'sd83443;
                14: r = 33'sd41722;
                15: r = 33'sd20861;
                16: r = 33'sd10430;
                17: r = 33'sd5215;
                18: r = 33'sd2608;
                19: r = 33'sd1304;
                20: r = 33'sd652;
                21: r = 33'sd326;
                22: r = 33'sd163;
                23: r = 33'sd81;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- hw/rtl/asmg_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asmg_divider
// Pipelined restoring divider, one quotient bit per stage. Carries a tag.
// ----------------------------------------------------------------------------
module asmg_divider #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 9,
    parameter int TAG_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [NUM_W-1:0] out_quo,
    output logic [TAG_W-1:0] out_tag
);
    logic             v_reg   [NUM_W+1];
    logic [NUM_W-1:0] q_reg   [NUM_W+1];
    logic [DEN_W:0]   r_reg   [NUM_W+1];
    logic [DEN_W-1:0] d_reg   [NUM_W+1];
    logic [TAG_W-1:0] t_reg   [NUM_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= NUM_W; i++) v_reg[i] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int i = 0; i < NUM_W; i++) v_reg[i+1] <= v_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg[0] <= in_num;
            r_reg[0] <= '0;
            d_reg[0] <= in_den;
            t_reg[0] <= in_tag;
            for (int i = 0; i < NUM_W; i++) begin
                logic [DEN_W+1:0] trial;
                trial = {r_reg[i], q_reg[i][NUM_W-1]};
                if (trial >= {2'b00, d_reg[i]}) begin
                    r_reg[i+1] <= (DEN_W+1)'(trial - {2'b00, d_reg[i]});
                    q_reg[i+1] <= {q_reg[i][NUM_W-2:0], 1'b1};
                end else begin
                    r_reg[i+1] <= trial[DEN_W:0];
                    q_reg[i+1] <= {q_reg[i][NUM_W-2:0], 1'b0};
                end
                d_reg[i+1] <= d_reg[i];
                t_reg[i+1] <= t_reg[i];
            end
        end
    end

    assign out_valid = v_reg[NUM_W];
    assign out_quo   = q_reg[NUM_W];
    assign out_tag   = t_reg[NUM_W];
endmodule

// ----- hw/rtl/asmg_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asmg_cordic
// Pipelined rotation CORDIC with quadrant fold; returns cosine and sine Q2.30.
// ----------------------------------------------------------------------------
module asmg_cordic #(
    parameter int STAGES = asmg_pkg::CORDIC_STAGES_DEF,
    parameter int TAG_W  = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [asmg_pkg::ANG_W-1:0]           in_angle,
    input  logic [TAG_W-1:0]                     in_tag,
    output logic                                 out_valid,
    output logic signed [asmg_pkg::TRIG_W-1:0]   out_cos,
    output logic signed [asmg_pkg::TRIG_W-1:0]   out_sin,
    output logic [TAG_W-1:0]                     out_tag
);
    import asmg_pkg::*;

    logic                     v_reg [STAGES+1];
    logic signed [TRIG_W:0]   x_reg [STAGES+1];
    logic signed [TRIG_W:0]   y_reg [STAGES+1];
    logic signed [ANG_W:0]    z_reg [STAGES+1];
    logic [1:0]               q_reg [STAGES+1];
    logic [TAG_W-1:0]         t_reg [STAGES+1];
    logic [ANG_W-1:0]         a_rot;

    assign a_rot = in_angle + 32'h2000_0000;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= STAGES; i++) v_reg[i] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int i = 0; i < STAGES; i++) v_reg[i+1] <= v_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= (TRIG_W+1)'(CORDIC_X0);
            y_reg[0] <= '0;
            z_reg[0] <= $signed({3'b000, a_rot[29:0]}) - 33'sh0_2000_0000;
            q_reg[0] <= a_rot[31:30];
            t_reg[0] <= in_tag;
            for (int k = 0; k < STAGES; k++) begin
                if (!z_reg[k][ANG_W]) begin
                    x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] - atan_turns(k);
                end else begin
                    x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] + atan_turns(k);
                end
                q_reg[k+1] <= q_reg[k];
                t_reg[k+1] <= t_reg[k];
            end
        end
    end

    logic signed [TRIG_W:0] xf, yf;
    assign xf = x_reg[STAGES];
    assign yf = y_reg[STAGES];

    always_comb begin
        case (q_reg[STAGES])
            2'd0:    begin out_cos = TRIG_W'(xf);  out_sin = TRIG_W'(yf);  end
            2'd1:    begin out_cos = TRIG_W'(-yf); out_sin = TRIG_W'(xf);  end
            2'd2:    begin out_cos = TRIG_W'(-xf); out_sin = TRIG_W'(-yf); end
            default: begin out_cos = TRIG_W'(yf);  out_sin = TRIG_W'(-xf); end
        endcase
    end

    assign out_valid = v_reg[STAGES];
    assign out_tag   = t_reg[STAGES];
endmodule

// ----- hw/rtl/annulus_sector_mesh_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annulus_sector_mesh_generator
// Emits the six triangle vertices of one segment of a configured ring sector.
//
// Input channel s_*: one segment index per item. Result channel m_*: six
// vertex items per input, in the order inner(i), outer(i), inner(i+1),
// inner(i+1), outer(i), outer(i+1); m_last marks the sixth.
// The cfg_* port writes the seven sector registers; the user must write them
// only while the block is idle, the block itself does not enforce it.
// Each edge angle goes through a 41-stage pipelined divider and a
// CORDIC_STAGES-deep pipelined CORDIC, both edges of a segment in parallel,
// then a multiply stage and a round/saturate stage. Each input's six
// vertices leave one at a time through the single result port.
// Results collect in a small queue; the input is stalled when the queue may
// not hold everything already in flight, so a stalled receiver loses nothing.
// Reset clears the pipeline, the queue and restores register defaults.
// ----------------------------------------------------------------------------
module annulus_sector_mesh_generator #(
    parameter int MAX_SEGMENTS  = asmg_pkg::MAX_SEGMENTS_DEF,
    parameter int CORDIC_STAGES = asmg_pkg::CORDIC_STAGES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_index,
    input  logic [asmg_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [asmg_pkg::IDX_W-1:0]  s_segment_index,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [15:0]          m_vertex_x,
    output logic signed [15:0]          m_vertex_y,
    output logic [2:0]                  m_vertex_number,
    output logic                        m_last,
    output logic                        m_invalid
);
    import asmg_pkg::*;

    localparam int NUM_W  = 41;
    // Approximate pipeline depth, used to size the output queue.
    localparam int LAT    = NUM_W + CORDIC_STAGES + 5;
    // Enough slots that a credit comes back before the input runs dry.
    localparam int SLOTS  = (LAT + 12) / 6;

    // configuration registers
    logic signed [15:0] cx_reg, cy_reg;
    logic [14:0] rin_reg, rout_reg;
    logic [15:0] start_reg;
    logic [16:0] sweep_reg;
    logic [8:0]  count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg <= '0; cy_reg <= '0;
            rin_reg <= 15'd9830; rout_reg <= 15'd16384;
            start_reg <= '0; sweep_reg <= 17'd65536; count_reg <= 9'd8;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CENTER_X:      cx_reg    <= cfg_data[15:0];
                REG_CENTER_Y:      cy_reg    <= cfg_data[15:0];
                REG_INNER_RADIUS:  rin_reg   <= cfg_data[14:0];
                REG_OUTER_RADIUS:  rout_reg  <= cfg_data[14:0];
                REG_START_ANGLE:   start_reg <= cfg_data[15:0];
                REG_SWEEP:         sweep_reg <= cfg_data;
                REG_SEGMENT_COUNT: count_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Free output queue room by whole items; credit also covers items in flight.
    logic [$clog2(SLOTS+1)-1:0] credit_reg;
    logic accept, item_done;
    assign s_ready = credit_reg != '0;
    assign accept  = s_valid && s_ready;

    // stage 0: index and configuration check and products
    logic        v0_reg, bad0_reg;
    logic [NUM_W-1:0] n0_reg, n1_reg;
    logic        bad_now;
    logic [8:0]  idx_ext;
    assign idx_ext = {1'b0, s_segment_index};
    assign bad_now = (rin_reg >= rout_reg) || (count_reg < 9'd2) ||
                     (32'(count_reg) > 32'(MAX_SEGMENTS)) || (sweep_reg == '0) ||
                     (sweep_reg > 17'd65536) || (idx_ext >= count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) v0_reg <= 1'b0;
        else          v0_reg <= accept;
    end
    always_ff @(posedge aclk) begin
        n0_reg   <= {(NUM_W-16)'(sweep_reg) * (NUM_W-16)'(idx_ext), 16'd0};
        n1_reg   <= {(NUM_W-16)'(sweep_reg) * (NUM_W-16)'(idx_ext + 9'd1), 16'd0};
        bad0_reg <= bad_now;
    end

    logic dv0, dv1;
    logic [NUM_W-1:0] q0, q1;
    logic [0:0] dt0, dt1;
    asmg_divider #(.NUM_W(NUM_W), .DEN_W(9), .TAG_W(1)) u_div0 (
        .aclk, .aresetn, .en(1'b1), .in_valid(v0_reg), .in_num(n0_reg),
        .in_den(count_reg), .in_tag(bad0_reg), .out_valid(dv0), .out_quo(q0),
        .out_tag(dt0));
    asmg_divider #(.NUM_W(NUM_W), .DEN_W(9), .TAG_W(1)) u_div1 (
        .aclk, .aresetn, .en(1'b1), .in_valid(v0_reg), .in_num(n1_reg),
        .in_den(count_reg), .in_tag(1'b0), .out_valid(dv1), .out_quo(q1),
        .out_tag(dt1));

    logic [31:0] a0, a1;
    assign a0 = {start_reg, 16'd0} + q0[31:0];
    assign a1 = {start_reg, 16'd0} + q1[31:0];

    logic cv0, cv1;
    logic signed [31:0] c0, s0, c1, s1;
    logic [0:0] ct0, ct1;
    asmg_cordic #(.STAGES(CORDIC_STAGES), .TAG_W(1)) u_cor0 (
        .aclk, .aresetn, .en(1'b1), .in_valid(dv0), .in_angle(a0),
        .in_tag(dt0), .out_valid(cv0), .out_cos(c0), .out_sin(s0), .out_tag(ct0));
    asmg_cordic #(.STAGES(CORDIC_STAGES), .TAG_W(1)) u_cor1 (
        .aclk, .aresetn, .en(1'b1), .in_valid(dv1), .in_angle(a1),
        .in_tag(dt1), .out_valid(cv1), .out_cos(c1), .out_sin(s1), .out_tag(ct1));

    // multiply stage: eight products radius * trig
    logic        mv_reg, mbad_reg;
    logic signed [47:0] p_reg [8];
    always_ff @(posedge aclk) begin
        if (!aresetn) mv_reg <= 1'b0;
        else          mv_reg <= cv0;
    end
    always_ff @(posedge aclk) begin
        mbad_reg <= ct0[0];
        p_reg[0] <= $signed({1'b0, rin_reg})  * c0;
        p_reg[1] <= $signed({1'b0, rin_reg})  * s0;
        p_reg[2] <= $signed({1'b0, rout_reg}) * c0;
        p_reg[3] <= $signed({1'b0, rout_reg}) * s0;
        p_reg[4] <= $signed({1'b0, rin_reg})  * c1;
        p_reg[5] <= $signed({1'b0, rin_reg})  * s1;
        p_reg[6] <= $signed({1'b0, rout_reg}) * c1;
        p_reg[7] <= $signed({1'b0, rout_reg}) * s1;
    end

    // round, add centre, saturate; zero for an invalid item
    function automatic logic [15:0] sat_coord(input logic signed [15:0] c,
                                              input logic signed [47:0] p);
        logic signed [47:0] r;
        logic signed [18:0] v;
        begin
            r = (p + 48'sh2000_0000) >>> 30;
            v = 19'(c) + 19'(r);
            if (v > 19'sd32767)       return 16'h7FFF;
            else if (v < -19'sd32768) return 16'h8000;
            else                      return v[15:0];
        end
    endfunction

    logic        rv_reg, rbad_reg;
    logic [15:0] rx_reg [4];
    logic [15:0] ry_reg [4];
    always_ff @(posedge aclk) begin
        if (!aresetn) rv_reg <= 1'b0;
        else          rv_reg <= mv_reg;
    end
    always_ff @(posedge aclk) begin
        rbad_reg <= mbad_reg;
        for (int j = 0; j < 4; j++) begin
            rx_reg[j] <= mbad_reg ? 16'd0 : sat_coord(cx_reg, p_reg[2*j]);
            ry_reg[j] <= mbad_reg ? 16'd0 : sat_coord(cy_reg, p_reg[2*j+1]);
        end
    end

    // Item queue: holds finished segments, six vertices read out in turn.
    localparam int SQ_W = $clog2(SLOTS);
    logic [33*4-1:0] sq_mem [SLOTS];
    logic [SQ_W-1:0] wp_reg, rp_reg;
    logic [SQ_W:0]   cnt_reg;
    logic [2:0]      vn_reg;

    always_ff @(posedge aclk) begin
        if (rv_reg)
            sq_mem[wp_reg] <= {rbad_reg, rx_reg[0], ry_reg[0], rx_reg[1], ry_reg[1],
                               rx_reg[2], ry_reg[2], rx_reg[3], ry_reg[3],
                               3'd0};
    end

    logic [33*4-1:0] head;
    assign head = sq_mem[rp_reg];
    assign m_valid = cnt_reg != '0;
    assign item_done = m_valid && m_ready && (vn_reg == 3'd5);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0; vn_reg <= '0;
            credit_reg <= ($clog2(SLOTS+1))'(SLOTS);
        end else begin
            if (rv_reg) wp_reg <= (wp_reg == SQ_W'(SLOTS-1)) ? '0 : wp_reg + 1'b1;
            if (item_done) rp_reg <= (rp_reg == SQ_W'(SLOTS-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (SQ_W+1)'(rv_reg) - (SQ_W+1)'(item_done);
            credit_reg <= credit_reg - ($clog2(SLOTS+1))'(accept)
                          + ($clog2(SLOTS+1))'(item_done);
            if (m_valid && m_ready) vn_reg <= item_done ? 3'd0 : vn_reg + 3'd1;
        end
    end

    // pick the vertex: 0 in(i), 1 out(i), 2,3 in(i+1), 4 out(i), 5 out(i+1)
    logic [1:0] sel;
    always_comb begin
        case (vn_reg)
            3'd0:          sel = 2'd0;
            3'd1, 3'd4:    sel = 2'd1;
            3'd2, 3'd3:    sel = 2'd2;
            default:       sel = 2'd3;
        endcase
    end

    logic [31:0] pair;
    always_comb begin
        case (sel)
            2'd0:    pair = head[130:99];
            2'd1:    pair = head[98:67];
            2'd2:    pair = head[66:35];
            default: pair = head[34:3];
        endcase
    end

    assign m_vertex_x      = pair[31:16];
    assign m_vertex_y      = pair[15:0];
    assign m_vertex_number = vn_reg;
    assign m_last          = vn_reg == 3'd5;
    assign m_invalid       = head[131];

    logic unused;
    assign unused = ^{cv1, ct1, dv1, head[2:0], q0[NUM_W-1:32], q1[NUM_W-1:32]};
endmodule
